// ===== src/periodic_oneshot_timer_table_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the timer table RTL.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_ONESHOT_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_ONESHOT_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define POTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define POTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pott_pkg.sv =====
// ---------------------------------------------------------------------------
// pott_pkg
// Types and constants of the periodic and one-shot timer table.
// ---------------------------------------------------------------------------
`default_nettype none

package pott_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [15:0] TICK_RESET = 16'd100;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        RES_START_ACK = 2'd0,
        RES_FIRED     = 2'd1,
        RES_STOP_ACK  = 2'd2
    } t_res_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] timeout;
        logic [31:0] last_fire;
        logic        one_shot;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// ===== src/pott_ram.sv =====
// ---------------------------------------------------------------------------
// pott_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ---------------------------------------------------------------------------
`default_nettype none

module pott_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/periodic_oneshot_timer_table.sv =====
// ---------------------------------------------------------------------------
// periodic_oneshot_timer_table
// Table of periodic and one-shot timers held in one RAM, walked in order.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  in        input      i_in_valid / o_in_stall   i_kind, i_timeout_ms,
//                                                 i_single_shot, i_stop_id
//  out       output     o_out_valid / i_out_stall o_result_kind, o_timer_id,
//                                                 o_ok, o_last
//  cfg       input      i_cfg_we                  i_cfg_wdata (tick_ms)
//
//  A start appends its entry if there is room; its beat reaches the output
//  register in the next cycle. A tick or a stop reads the RAM one entry per
//  cycle unless a stall holds it, and compacts the table in the same pass.
//  A fired beat is held one step back so that the final one can carry o_last;
//  a stalled output register pauses the walk. Synchronous reset clears the
//  control state only; the RAM needs no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

`include "periodic_oneshot_timer_table_defines.svh"

module periodic_oneshot_timer_table #(
    parameter int MAX_TIMERS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_timeout_ms,
    input  wire logic        i_single_shot,
    input  wire logic [31:0] i_stop_id,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_result_kind,
    output logic [31:0]      o_timer_id,
    output logic             o_ok,
    output logic             o_last,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam int AW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam int RW = pott_pkg::RES_W;

    pott_pkg::t_state    r_state, n_state;
    logic [15:0]         r_tick_ms;
    logic [31:0]         r_now, n_now;
    logic [31:0]         r_id, n_id;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic [CW-1:0]       r_wr_idx, n_wr_idx;
    logic                r_ev_valid, n_ev_valid;
    logic                r_mode_stop, n_mode_stop;
    logic                r_found, n_found;
    logic [31:0]         r_sid, n_sid;
    logic [RW-1:0]       r_res_cnt, n_res_cnt;
    logic                r_pend_valid, n_pend_valid;
    logic [31:0]         r_pend_id, n_pend_id;

    logic                  r_out_valid, n_out_valid;
    pott_pkg::t_res_kind   r_out_kind, n_out_kind;
    logic [31:0]           r_out_id, n_out_id;
    logic                  r_out_ok, n_out_ok;
    logic                  r_out_last, n_out_last;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    pott_pkg::t_entry              ram_wentry;
    logic                          ram_re;
    logic [pott_pkg::ENTRY_W-1:0]  ram_rdata;
    pott_pkg::t_entry              ev;

    logic        out_free;
    logic        accept;
    logic        ev_fire;
    logic        ev_match;
    logic        ev_drop;
    logic        can_go;
    logic        go;
    logic        walk_done;
    logic [31:0] start_id;
    logic        room;

    pott_ram #(
        .WIDTH (pott_pkg::ENTRY_W),
        .DEPTH (MAX_TIMERS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wentry),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign ev = pott_pkg::t_entry'(ram_rdata);

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != pott_pkg::ST_IDLE) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign start_id = r_id + 32'd1;
    assign room     = r_count < CW'(MAX_TIMERS);

    // Elapsed time is taken modulo 2^32, so the subtraction simply wraps.
    assign ev_fire  = !r_mode_stop && (r_res_cnt != RW'(pott_pkg::MAX_RESULTS))
                      && ((r_now - ev.last_fire) >= ev.timeout);
    assign ev_match = r_mode_stop && !r_found && (ev.id == r_sid);
    assign ev_drop  = (ev_fire && ev.one_shot) || ev_match;
    assign can_go   = !(ev_fire && r_pend_valid && !out_free);
    assign go       = r_ev_valid && can_go;
    assign walk_done = !r_ev_valid && (r_rd_idx == r_count);

    assign ram_re = (r_state == pott_pkg::ST_WALK) && (r_rd_idx != r_count)
                    && (!r_ev_valid || can_go);

    always_comb begin
        n_state      = r_state;
        n_now        = r_now;
        n_id         = r_id;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_wr_idx     = r_wr_idx;
        n_ev_valid   = r_ev_valid;
        n_mode_stop  = r_mode_stop;
        n_found      = r_found;
        n_sid        = r_sid;
        n_res_cnt    = r_res_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_kind   = r_out_kind;
        n_out_id     = r_out_id;
        n_out_ok     = r_out_ok;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = r_wr_idx[AW-1:0];
        ram_wentry   = ev;

        case (r_state)
            pott_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        pott_pkg::KIND_START: begin
                            n_id = start_id;
                            if (room) begin
                                ram_we               = 1'b1;
                                ram_waddr            = r_count[AW-1:0];
                                ram_wentry.id        = start_id;
                                ram_wentry.timeout   = i_timeout_ms;
                                ram_wentry.last_fire = r_now;
                                ram_wentry.one_shot  = i_single_shot;
                                n_count              = r_count + CW'(1);
                            end
                            n_out_valid = 1'b1;
                            n_out_kind  = pott_pkg::RES_START_ACK;
                            n_out_id    = start_id;
                            n_out_ok    = room;
                            n_out_last  = 1'b1;
                        end
                        pott_pkg::KIND_STOP, pott_pkg::KIND_TICK: begin
                            n_mode_stop  = (i_kind == pott_pkg::KIND_STOP);
                            n_sid        = i_stop_id;
                            n_found      = 1'b0;
                            n_res_cnt    = '0;
                            n_pend_valid = 1'b0;
                            n_rd_idx     = '0;
                            n_wr_idx     = '0;
                            n_ev_valid   = 1'b0;
                            if (i_kind == pott_pkg::KIND_TICK) begin
                                n_now = r_now + 32'(r_tick_ms);
                            end
                            n_state = pott_pkg::ST_WALK;
                        end
                        default: begin
                            // The unused kind is taken and dropped.
                        end
                    endcase
                end
            end

            pott_pkg::ST_WALK: begin
                if (go) begin
                    if (ev_fire) begin
                        ram_wentry.last_fire = r_now;
                        n_res_cnt            = r_res_cnt + RW'(1);
                        n_pend_valid         = 1'b1;
                        n_pend_id            = ev.id;
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = pott_pkg::RES_FIRED;
                            n_out_id    = r_pend_id;
                            n_out_ok    = 1'b1;
                            n_out_last  = 1'b0;
                        end
                    end
                    if (ev_match) begin
                        n_found = 1'b1;
                    end
                    // Kept entries slide down to the write index, closing gaps.
                    if (!ev_drop) begin
                        ram_we   = 1'b1;
                        n_wr_idx = r_wr_idx + CW'(1);
                    end
                end
                if (ram_re) begin
                    n_rd_idx   = r_rd_idx + CW'(1);
                    n_ev_valid = 1'b1;
                end else if (go) begin
                    n_ev_valid = 1'b0;
                end
                if (walk_done) begin
                    n_count = r_wr_idx;
                    n_state = pott_pkg::ST_FIN;
                end
            end

            pott_pkg::ST_FIN: begin
                if (out_free) begin
                    if (r_mode_stop) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = pott_pkg::RES_STOP_ACK;
                        n_out_id    = r_sid;
                        n_out_ok    = r_found;
                        n_out_last  = 1'b1;
                    end else if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = pott_pkg::RES_FIRED;
                        n_out_id    = r_pend_id;
                        n_out_ok    = 1'b1;
                        n_out_last  = 1'b1;
                    end
                    n_pend_valid = 1'b0;
                    n_state      = pott_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = pott_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pott_pkg::ST_IDLE;
            r_tick_ms    <= pott_pkg::TICK_RESET;
            r_now        <= '0;
            r_id         <= '0;
            r_count      <= '0;
            r_rd_idx     <= '0;
            r_wr_idx     <= '0;
            r_ev_valid   <= 1'b0;
            r_mode_stop  <= 1'b0;
            r_found      <= 1'b0;
            r_res_cnt    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) begin
                r_tick_ms <= i_cfg_wdata;
            end
            r_now        <= n_now;
            r_id         <= n_id;
            r_count      <= n_count;
            r_rd_idx     <= n_rd_idx;
            r_wr_idx     <= n_wr_idx;
            r_ev_valid   <= n_ev_valid;
            r_mode_stop  <= n_mode_stop;
            r_found      <= n_found;
            r_res_cnt    <= n_res_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sid      <= n_sid;
        r_pend_id  <= n_pend_id;
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_ok   <= n_out_ok;
        r_out_last <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_timer_id    = r_out_id;
    assign o_ok          = r_out_ok;
    assign o_last        = r_out_last;

    `POTT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_TIMERS), "table count exceeds capacity")
    `POTT_ASSERT_NOW(a_wr_behind_rd, i_clk, i_rst_n, r_state == pott_pkg::ST_WALK, r_wr_idx <= r_rd_idx, "compaction write index passed read index")
    `POTT_ASSERT_NOW(a_pend_in_walk, i_clk, i_rst_n, r_pend_valid, (r_state != pott_pkg::ST_IDLE) && !r_mode_stop, "pending fired beat outside a tick walk")
    `POTT_ASSERT_NEXT(a_start_grows, i_clk, i_rst_n, (r_state == pott_pkg::ST_IDLE) && accept && (i_kind == pott_pkg::KIND_START) && room, r_count == $past(r_count) + CW'(1), "start with room did not append")

endmodule

`default_nettype wire

// ===== tb/tb_periodic_oneshot_timer_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_periodic_oneshot_timer_table
// Self-checking bench for the periodic and one-shot timer table. A directed
// run covers the corner cases: an empty table, a full table, unknown ids,
// zero and all-ones timeouts, a zero tick step and the unused kind. Random
// runs with several tick_ms settings follow. A local model of the table
// predicts every result beat, and the monitor checks each beat in order.
// ---------------------------------------------------------------------------

module tb_periodic_oneshot_timer_table;

    localparam int          NUM_TIMERS  = 16;
    localparam int          LONG_HOLD   = 400;
    localparam int          CYCLE_LIMIT = 3_000_000;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] timeout;
        logic        single_shot;
        logic [31:0] stop_id;
    } t_req;

    typedef struct {
        pott_pkg::t_res_kind kind;
        logic [31:0]         id;
        logic                ok;
        logic                last;
    } t_res;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [1:0]  in_kind        = '0;
    logic [31:0] in_timeout_ms  = '0;
    logic        in_single_shot = 1'b0;
    logic [31:0] in_stop_id     = '0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [1:0]  res_kind;
    logic [31:0] res_timer_id;
    logic        res_ok;
    logic        res_last;
    logic        cfg_we         = 1'b0;
    logic [15:0] cfg_wdata      = '0;

    periodic_oneshot_timer_table #(
        .MAX_TIMERS (NUM_TIMERS)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_kind        (in_kind),
        .i_timeout_ms  (in_timeout_ms),
        .i_single_shot (in_single_shot),
        .i_stop_id     (in_stop_id),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_result_kind (res_kind),
        .o_timer_id    (res_timer_id),
        .o_ok          (res_ok),
        .o_last        (res_last),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata)
    );

    // Local copy of the timer table.
    logic [15:0] tick_step = pott_pkg::TICK_RESET;
    logic [31:0] clock_ms  = '0;
    logic [31:0] next_id   = '0;
    int          tbl_count = 0;
    logic [31:0] tbl_id        [NUM_TIMERS];
    logic [31:0] tbl_timeout   [NUM_TIMERS];
    logic [31:0] tbl_last_fire [NUM_TIMERS];
    logic        tbl_one_shot  [NUM_TIMERS];

    t_req        request_q[$];
    t_res        due_results[$];
    t_req        cur_req;
    t_res        want;

    // Stimulus-side bookkeeping.
    logic [31:0] gen_ids  = '0;
    logic [15:0] gen_tick = pott_pkg::TICK_RESET;
    logic        tx_steady = 1'b0;
    logic        rx_quiet  = 1'b0;
    int          holds_asked  = 0;
    int          holds_served = 0;
    int          tx_gap    = 0;
    int          rx_left   = 0;
    int          hold_left = 0;
    int          cycle_cnt = 0;

    int err_cnt   = 0;
    int n_checked = 0;
    int n_ticks   = 0;
    int n_starts  = 0;
    int n_stops   = 0;
    int n_ignored = 0;
    int n_fired   = 0;
    int n_refused = 0;
    int n_missed  = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void expect_beat(input pott_pkg::t_res_kind kind, input logic [31:0] id,
                                        input logic ok, input logic last);
        t_res b;
        b.kind = kind;
        b.id   = id;
        b.ok   = ok;
        b.last = last;
        due_results.insert(due_results.size(), b);
    endfunction

    // Removes one entry and closes the gap, keeping table order.
    function automatic void drop_entry(input int pos);
        for (int j = pos; j + 1 < tbl_count; j++) begin
            tbl_id[j]        = tbl_id[j + 1];
            tbl_timeout[j]   = tbl_timeout[j + 1];
            tbl_last_fire[j] = tbl_last_fire[j + 1];
            tbl_one_shot[j]  = tbl_one_shot[j + 1];
        end
        tbl_count--;
    endfunction

    function automatic void apply_request(input t_req r);
        int          pos;
        int          n;
        logic        hit;
        logic [31:0] elapsed;
        n   = 0;
        hit = 1'b0;
        case (r.kind)
            pott_pkg::KIND_START: begin
                n_starts++;
                next_id = next_id + 32'd1;
                if (tbl_count < NUM_TIMERS) begin
                    tbl_id[tbl_count]        = next_id;
                    tbl_timeout[tbl_count]   = r.timeout;
                    tbl_last_fire[tbl_count] = clock_ms;
                    tbl_one_shot[tbl_count]  = r.single_shot;
                    tbl_count++;
                    hit = 1'b1;
                end else begin
                    n_refused++;
                end
                expect_beat(pott_pkg::RES_START_ACK, next_id, hit, 1'b1);
            end
            pott_pkg::KIND_STOP: begin
                n_stops++;
                for (pos = 0; pos < tbl_count && !hit; pos++) begin
                    if (tbl_id[pos] == r.stop_id) begin
                        drop_entry(pos);
                        hit = 1'b1;
                    end
                end
                if (!hit) n_missed++;
                expect_beat(pott_pkg::RES_STOP_ACK, r.stop_id, hit, 1'b1);
            end
            pott_pkg::KIND_TICK: begin
                n_ticks++;
                clock_ms = clock_ms + {16'd0, tick_step};
                pos = 0;
                while (pos < tbl_count && n < pott_pkg::MAX_RESULTS) begin
                    elapsed = clock_ms - tbl_last_fire[pos];
                    if (elapsed >= tbl_timeout[pos]) begin
                        tbl_last_fire[pos] = clock_ms;
                        expect_beat(pott_pkg::RES_FIRED, tbl_id[pos], 1'b1, 1'b0);
                        n++;
                        n_fired++;
                        // A one-shot timer leaves; the next entry slides into pos.
                        if (tbl_one_shot[pos]) drop_entry(pos);
                        else pos++;
                    end else begin
                        pos++;
                    end
                end
                if (n > 0) due_results[due_results.size() - 1].last = 1'b1;
            end
            default: n_ignored++;
        endcase
    endfunction

    function automatic void queue_request(input t_req r);
        if (r.kind == pott_pkg::KIND_START) gen_ids = gen_ids + 32'd1;
        request_q.insert(request_q.size(), r);
    endfunction

    function automatic void queue_fields(input logic [1:0] kind, input logic [31:0] timeout,
                                         input logic single_shot, input logic [31:0] stop_id);
        t_req r;
        r.kind        = kind;
        r.timeout     = timeout;
        r.single_shot = single_shot;
        r.stop_id     = stop_id;
        queue_request(r);
    endfunction

    function automatic logic [31:0] pick_timeout();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 32'd0;
        if (r < 45) return gen_tick * $urandom_range(1, 4);
        if (r < 75) return $urandom_range(0, 5 * int'(gen_tick));
        if (r < 85) return $urandom;
        return 32'hFFFF_FFFF - $urandom_range(0, 1000);
    endfunction

    // Mostly recent ids, some of them still live; ids not yet issued always miss.
    function automatic logic [31:0] pick_stop_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return gen_ids - $urandom_range(0, 20);
        if (r < 85) return $urandom;
        return gen_ids + 32'd1 + $urandom_range(0, 3);
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick;
        r.timeout     = $urandom;
        r.single_shot = 1'($urandom_range(0, 1));
        r.stop_id     = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            r.kind = pott_pkg::KIND_TICK;
        end else if (pick < 72) begin
            r.kind    = pott_pkg::KIND_START;
            r.timeout = pick_timeout();
        end else if (pick < 95) begin
            r.kind    = pott_pkg::KIND_STOP;
            r.stop_id = pick_stop_id();
        end else begin
            r.kind = KIND_UNUSED;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (exp_val !== got_val) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h, got %0h",
                     $time, name, exp_val, got_val);
        end
    endfunction

    // Driver: the beat on the bus is predicted at the edge that accepts it.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (in_valid && !in_stall) apply_request(cur_req);
            if (!in_valid || !in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    cur_req = request_q.pop_front();
                    in_kind        <= cur_req.kind;
                    in_timeout_ms  <= cur_req.timeout;
                    in_single_shot <= cur_req.single_shot;
                    in_stop_id     <= cur_req.stop_id;
                    in_valid       <= 1'b1;
                    tx_gap         <= tx_steady ? 0 : idle_len();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall runs, plus a long hold whenever one is asked for.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_left   <= 0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
            out_stall    <= 1'b1;
        end else if (rx_quiet) begin
            out_stall <= 1'b0;
        end else if (rx_left > 0) begin
            rx_left <= rx_left - 1;
        end else begin
            out_stall <= ($urandom_range(0, 3) == 0);
            rx_left   <= idle_len();
        end
    end

    // Monitor.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            n_checked++;
            if (due_results.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result beat, expected none, got kind %0d id %0h",
                         $time, res_kind, res_timer_id);
            end else begin
                want = due_results.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(res_kind));
                check_field("timer_id", want.id, res_timer_id);
                check_field("ok", 32'(want.ok), 32'(res_ok));
                check_field("last", 32'(want.last), 32'(res_last));
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d results outstanding.",
                     due_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Waits, sampling between edges, until nothing is left to send or check and
    // the block has finished its last walk.
    task automatic drain_all();
        do @(negedge clk);
        while (request_q.size() != 0 || in_valid || in_stall || due_results.size() != 0);
    endtask

    task automatic write_tick(input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        tick_step = value;
        gen_tick  = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input logic [15:0] tick_val, input int count,
                              input logic steady, input logic long_hold);
        write_tick(tick_val);
        tx_steady = steady;
        rx_quiet  = steady;
        if (long_hold) holds_asked++;
        for (int k = 0; k < count; k++) queue_request(random_request());
        drain_all();
        tx_steady = 1'b0;
        rx_quiet  = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset value of tick_ms (100) in force.
        queue_fields(pott_pkg::KIND_TICK, 32'd0, 1'b0, 32'd0);
        queue_fields(KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        queue_fields(pott_pkg::KIND_START, 32'd0, 1'b0, 32'd0);
        queue_fields(pott_pkg::KIND_START, 32'd100, 1'b1, 32'd0);
        queue_fields(pott_pkg::KIND_START, 32'hFFFF_FFFF, 1'b0, 32'd0);
        queue_fields(pott_pkg::KIND_START, 32'd250, 1'b0, 32'd0);
        queue_fields(pott_pkg::KIND_TICK, 32'd0, 1'b0, 32'd0);
        queue_fields(pott_pkg::KIND_TICK, 32'd0, 1'b0, 32'd0);
        queue_fields(pott_pkg::KIND_TICK, 32'd0, 1'b0, 32'd0);
        queue_fields(pott_pkg::KIND_STOP, 32'd0, 1'b0, 32'd3);
        queue_fields(pott_pkg::KIND_STOP, 32'd0, 1'b0, 32'd3);
        queue_fields(pott_pkg::KIND_STOP, 32'd0, 1'b0, 32'd0);
        queue_fields(pott_pkg::KIND_STOP, 32'd0, 1'b0, 32'hFFFF_FFFF);
        // Fill the table and run one start past full.
        for (int k = 0; k < 15; k++)
            queue_fields(pott_pkg::KIND_START,
                         (k % 3 == 0) ? 32'd0 : (k % 3 == 1) ? 32'hFFFF_FFFF : 32'(100 * k),
                         k[0], 32'd0);
        queue_fields(pott_pkg::KIND_TICK, 32'd0, 1'b0, 32'd0);
        drain_all();

        // A zero tick step leaves the clock alone but still walks the table.
        write_tick(16'd0);
        queue_fields(pott_pkg::KIND_STOP, 32'd0, 1'b0, 32'd1);
        queue_fields(pott_pkg::KIND_TICK, 32'd0, 1'b0, 32'd0);
        queue_fields(pott_pkg::KIND_START, 32'd0, 1'b1, 32'd0);
        queue_fields(pott_pkg::KIND_TICK, 32'd0, 1'b0, 32'd0);
        queue_fields(pott_pkg::KIND_TICK, 32'd0, 1'b0, 32'd0);
        drain_all();

        run_random(16'hFFFF, 86, 1'b1, 1'b0);
        run_random(16'd1, 86, 1'b0, 1'b0);
        run_random(16'd100, 86, 1'b0, 1'b1);
        run_random(16'($urandom_range(2, 65534)), 86, 1'b0, 1'b0);
        run_random(16'hFFFF, 86, 1'b0, 1'b0);

        $display("Sent %0d ticks, %0d starts, %0d stops and %0d beats of the unused kind.",
                 n_ticks, n_starts, n_stops, n_ignored);
        $display("Checked %0d result beats: %0d firings, %0d refused starts, %0d missed stops.",
                 n_checked, n_fired, n_refused, n_missed);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/pott_pkg.sv
src/pott_ram.sv
src/periodic_oneshot_timer_table.sv
tb/tb_periodic_oneshot_timer_table.sv
